[rtl/core/xml_json_escape_encoder_unit_assert.svh]
// Assertion macros used by the escape encoder back end
`ifndef XML_JSON_ESCAPE_ENCODER_UNIT_ASSERT_SVH
`define XML_JSON_ESCAPE_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define XJE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("escape encoder check failed");

// Next-cycle implication, checked outside reset
`define XJE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("escape encoder check failed");

`endif

[rtl/core/xje_pkg.sv]
// Types, character codes and expansion functions of the escape encoder
package xje_pkg;

	localparam int XJE_QUEUE_DEPTH = 4;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_APOS  = 8'h27;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;

	// How the byte body of one item expands
	typedef enum logic [2:0] {
		BODY_PLAIN,
		BODY_LT,
		BODY_GT,
		BODY_AMP,
		BODY_QUOT,
		BODY_APOS,
		BODY_BSL
	} body_kind_t;

	// One classified item; for BODY_BSL ch holds the character after the backslash
	typedef struct packed {
		logic [7:0] ch;
		body_kind_t kind;
		logic       open_quote;
		logic       close_quote;
	} esc_desc_t;

	// Number of body bytes, 1 to 6
	function automatic logic [2:0] body_len(input body_kind_t kind);
		logic [2:0] n;
		unique case (kind)
			BODY_PLAIN: n = 3'd1;
			BODY_BSL:   n = 3'd2;
			BODY_LT,
			BODY_GT:    n = 3'd4;
			BODY_AMP:   n = 3'd5;
			BODY_QUOT,
			BODY_APOS:  n = 3'd6;
			default:    n = 3'd1;
		endcase
		return n;
	endfunction

	// Body byte at position idx, first byte in the top of the string
	function automatic logic [7:0] body_byte(input body_kind_t kind, input logic [7:0] ch,
			input logic [2:0] idx);
		logic [47:0] s;
		logic [47:0] sh;
		unique case (kind)
			BODY_LT:   s = {"&lt;", 16'h0};
			BODY_GT:   s = {"&gt;", 16'h0};
			BODY_AMP:  s = {"&amp;", 8'h0};
			BODY_QUOT: s = "&quot;";
			BODY_APOS: s = "&apos;";
			BODY_BSL:  s = {CH_BSL, ch, 32'h0};
			default:   s = {ch, 40'h0};
		endcase
		sh = s << {idx, 3'b000};
		return sh[47:40];
	endfunction

endpackage

[rtl/core/xml_json_escape_encoder_unit.sv]
// Path: an input beat accepted into an empty block is registered in the descriptor queue, then in the output register.
// Throughput: one output beat per cycle while m_tready is high; an input expands into 1 to 8 output beats,
// set by its expansion length in the back-end sequencer. Input beats are taken every cycle while the
// descriptor queue (QUEUE_DEPTH entries) has room.
// Reset: queue empty, no output beat valid, JSON quoting selected.
module xml_json_escape_encoder_unit
	import xje_pkg::*;
#(
	parameter int QUEUE_DEPTH = XJE_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wen,
	input  logic       cfg_wdata,   // json_quoting
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,     // [7:0] in_byte
	input  logic [1:0] s_tuser,     // [0] xml_escape, [1] first_of_string
	input  logic       s_tlast,     // last_of_string
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,     // [7:0] out_byte
	output logic       m_tlast      // last_out
);

	esc_desc_t desc;
	esc_desc_t head_data;
	logic      full;
	logic      head_valid;
	logic      pop;
	logic      push;

	// Classify the incoming beat
	xje_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wen         (cfg_wen),
		.cfg_wdata       (cfg_wdata),
		.in_byte         (s_tdata),
		.xml_escape      (s_tuser[0]),
		.first_of_string (s_tuser[1]),
		.last_of_string  (s_tlast),
		.desc            (desc)
	);

	assign s_tready = !full;
	assign push     = s_tvalid && !full;

	// Buffer classified beats
	xje_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (desc),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	// Expand into output beats
	xje_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

[rtl/core/xje_front.sv]
// Front end: mode register and classification of each input byte
module xje_front
	import xje_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wen,
	input  logic       cfg_wdata,
	input  logic [7:0] in_byte,
	input  logic       xml_escape,
	input  logic       first_of_string,
	input  logic       last_of_string,
	output esc_desc_t  desc
);

	logic       json_q;
	body_kind_t kind;
	logic [7:0] ch;

	// Hold the quoting mode; set to JSON at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			json_q <= 1'b1;
		end else if (cfg_wen) begin
			json_q <= cfg_wdata;
		end
	end

	// Pick the expansion: XML entities first, then backslash escapes in JSON mode
	always_comb begin
		kind = BODY_PLAIN;
		ch   = in_byte;
		if (xml_escape) begin
			unique case (in_byte)
				CH_LT:    kind = BODY_LT;
				CH_GT:    kind = BODY_GT;
				CH_AMP:   kind = BODY_AMP;
				CH_QUOTE: kind = BODY_QUOT;
				CH_APOS:  kind = BODY_APOS;
				default:  kind = BODY_PLAIN;
			endcase
		end
		if (kind == BODY_PLAIN && json_q) begin
			unique case (in_byte)
				CH_QUOTE: begin
					if (!xml_escape) begin
						kind = BODY_BSL;
						ch   = CH_QUOTE;
					end
				end
				CH_BSL: begin
					kind = BODY_BSL;
					ch   = CH_BSL;
				end
				CH_BS: begin
					kind = BODY_BSL;
					ch   = "b";
				end
				CH_FF: begin
					kind = BODY_BSL;
					ch   = "f";
				end
				CH_LF: begin
					kind = BODY_BSL;
					ch   = "n";
				end
				CH_CR: begin
					kind = BODY_BSL;
					ch   = "r";
				end
				CH_TAB: begin
					kind = BODY_BSL;
					ch   = "t";
				end
				default: begin
				end
			endcase
		end
	end

	assign desc.ch          = ch;
	assign desc.kind        = kind;
	assign desc.open_quote  = json_q & first_of_string;
	assign desc.close_quote = json_q & last_of_string;

endmodule

[rtl/core/xje_queue.sv]
// Short descriptor queue between front and back end
module xje_queue
	import xje_pkg::*;
#(
	parameter int DEPTH = XJE_QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  esc_desc_t push_data,
	output logic      full,
	input  logic      pop,
	output logic      head_valid,
	output esc_desc_t head_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	esc_desc_t          mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];

	// Store pushed descriptors
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/xje_back.sv]
// Back end: expands the head descriptor into output beats
`include "xml_json_escape_encoder_unit_assert.svh"
module xje_back
	import xje_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  esc_desc_t  head_data,
	output logic       pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic       m_tlast
);

	logic [2:0] pos_q;
	logic       m_tvalid_q;
	logic [7:0] m_tdata_q;
	logic       m_tlast_q;
	logic [3:0] total;
	logic [2:0] last_pos;
	logic [2:0] body_idx;
	logic [2:0] blen;
	logic       is_last;
	logic       load;
	logic [7:0] beat_byte;

	// Work out this beat's byte from the position within the expansion
	always_comb begin
		blen      = body_len(head_data.kind);
		total     = 4'(head_data.open_quote) + 4'(blen) + 4'(head_data.close_quote);
		last_pos  = 3'(total - 4'd1);
		body_idx  = pos_q - 3'(head_data.open_quote);
		is_last   = (pos_q == last_pos);
		if (head_data.open_quote && pos_q == 3'd0) begin
			beat_byte = CH_QUOTE;
		end else if (body_idx < blen) begin
			beat_byte = body_byte(head_data.kind, head_data.ch, body_idx);
		end else begin
			beat_byte = CH_QUOTE;
		end
	end

	assign load = head_valid && (!m_tvalid_q || m_tready);
	assign pop  = load && is_last;

	// Step through the expansion; drop the descriptor after its last beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (load) begin
				pos_q <= is_last ? 3'd0 : pos_q + 3'd1;
			end
			if (load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata_q <= beat_byte;
			m_tlast_q <= is_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	`XJE_ASSERT_NOW(a_mid_item_has_head, pos_q != 3'd0, head_valid)
	`XJE_ASSERT_NOW(a_pos_in_range, head_valid, pos_q <= last_pos)
	`XJE_ASSERT_NEXT(a_pos_steps, load && !is_last, pos_q == $past(pos_q) + 3'd1)

endmodule

[dv/tb.sv]
// Testbench for the XML/JSON escape encoder: checks every output beat against an expansion model
`timescale 1ns / 1ps

typedef struct packed {
	logic [7:0] data;
	logic       last;
} text_beat_t;

// Expands accepted text bytes into the escaped beats the block should send, and checks them
class escape_tracker;
	bit         json_mode;
	text_beat_t expected_beats[$];
	int         errors;
	int         beats_seen;

	function new();
		json_mode = 1'b1;
		errors = 0;
		beats_seen = 0;
	endfunction

	// Build the escaped sequence for one text byte and queue it
	function void expand_byte(logic [7:0] c, logic xml, logic first, logic last);
		logic [7:0] seq[$];
		string      ent;
		logic [7:0] esc;
		bit         done;
		text_beat_t b;
		ent = "";
		esc = 8'h00;
		done = 0;
		if (json_mode && first)
			seq.push_back(xje_pkg::CH_QUOTE);
		// XML entities for flagged bytes
		if (xml) begin
			case (c)
				xje_pkg::CH_LT:    ent = "&lt;";
				xje_pkg::CH_GT:    ent = "&gt;";
				xje_pkg::CH_AMP:   ent = "&amp;";
				xje_pkg::CH_QUOTE: ent = "&quot;";
				xje_pkg::CH_APOS:  ent = "&apos;";
				default:           ent = "";
			endcase
			if (ent.len() != 0) begin
				for (int i = 0; i < ent.len(); i++)
					seq.push_back(ent[i]);
				done = 1;
			end
		end
		// Backslash escapes in JSON mode; a bare quote only when unflagged
		if (!done && json_mode) begin
			if (!xml && c == xje_pkg::CH_QUOTE) begin
				esc = xje_pkg::CH_QUOTE;
			end else begin
				case (c)
					xje_pkg::CH_BSL: esc = xje_pkg::CH_BSL;
					xje_pkg::CH_BS:  esc = "b";
					xje_pkg::CH_FF:  esc = "f";
					xje_pkg::CH_LF:  esc = "n";
					xje_pkg::CH_CR:  esc = "r";
					xje_pkg::CH_TAB: esc = "t";
					default:         esc = 8'h00;
				endcase
			end
			if (esc != 8'h00) begin
				seq.push_back(xje_pkg::CH_BSL);
				seq.push_back(esc);
				done = 1;
			end
		end
		if (!done)
			seq.push_back(c);
		if (json_mode && last)
			seq.push_back(xje_pkg::CH_QUOTE);
		foreach (seq[i]) begin
			b.data = seq[i];
			b.last = (i == seq.size() - 1);
			expected_beats.push_back(b);
		end
	endfunction

	task report_mismatch(string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	// Compare one output beat with the oldest expected beat
	task check_beat(logic [7:0] data, logic last);
		text_beat_t e;
		beats_seen++;
		if (expected_beats.size() == 0) begin
			report_mismatch($sformatf("unexpected beat data %02h last %0b", data, last));
		end else begin
			e = expected_beats.pop_front();
			if (data !== e.data)
				report_mismatch($sformatf("beat %0d data %02h, wanted %02h",
					beats_seen, data, e.data));
			if (last !== e.last)
				report_mismatch($sformatf("beat %0d last %0b, wanted %0b",
					beats_seen, last, e.last));
		end
	endtask
endclass

module tb;
	import xje_pkg::*;

	localparam int RANDOM_ITEMS = 136;
	localparam int PHASE_ITEMS  = 40;
	localparam int QUIET_ITEMS  = 30;
	localparam int CYCLE_LIMIT  = 200000;

	localparam logic [7:0] SPECIAL_CHARS [11] = '{CH_LT, CH_GT, CH_AMP, CH_QUOTE, CH_APOS,
		CH_BSL, CH_BS, CH_FF, CH_LF, CH_CR, CH_TAB};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wen = 1'b0;
	logic       cfg_wdata = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic [1:0] s_tuser = 2'b00;   // [0] xml_escape, [1] first_of_string
	logic       s_tlast = 1'b0;    // last_of_string
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;           // [7:0] out_byte
	logic       m_tlast;           // last_out

	escape_tracker tracker;
	bit            quiet = 1'b0;
	int            items_sent = 0;
	int            mode_writes = 0;
	int            cycles = 0;

	xml_json_escape_encoder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Abort a run that hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	// Sample the output beat mid-cycle, where every signal has settled for the next edge
	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_beat(m_tdata, m_tlast);
	end

	// Receiver: stall in random bursts, never in the quiet tail
	initial begin
		@(posedge arst_n);
		forever begin
			if (!quiet && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	end

	// Present one text beat and hold it until taken; valid stays high on return
	task send_text(logic [7:0] c, logic xml, logic first, logic last);
		bit took;
		took = 0;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tuser <= {first, xml};
		s_tlast <= last;
		do begin
			@(negedge clk);
			took = s_tready;
			@(posedge clk);
		end while (!took);
		tracker.expand_byte(c, xml, first, last);
		items_sent++;
	endtask

	task wait_drained();
		while (tracker.expected_beats.size() != 0)
			@(posedge clk);
	endtask

	// Drop valid, let every expected beat out, then write the quoting register
	task set_json_quoting(bit v);
		s_tvalid <= 1'b0;
		wait_drained();
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		tracker.json_mode = v;
		mode_writes++;
	endtask

	function automatic logic [7:0] pick_char();
		if ($urandom_range(0, 1) == 0)
			return SPECIAL_CHARS[$urandom_range(0, 10)];
		return 8'($urandom_range(0, 255));
	endfunction

	// One string of random content; noise strings carry random boundary flags
	task send_string(int len, bit noise);
		logic seg_xml;
		logic first;
		logic last;
		seg_xml = 1'($urandom_range(0, 1));
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 3) == 0)
				seg_xml = ~seg_xml;
			first = (i == 0);
			last = (i == len - 1);
			if (noise) begin
				first = 1'($urandom_range(0, 1));
				last = 1'($urandom_range(0, 1));
			end
			send_text(pick_char(), seg_xml, first, last);
		end
	endtask

	initial begin
		int target;
		int phase;
		tracker = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: JSON mode, widest expansion on a one-byte string
		set_json_quoting(1'b1);
		send_text(CH_QUOTE, 1'b1, 1'b1, 1'b1);
		// Every special character within one string, some flagged and some unflagged
		send_text(CH_LT,    1'b1, 1'b1, 1'b0);
		send_text(CH_GT,    1'b1, 1'b0, 1'b0);
		send_text(CH_AMP,   1'b1, 1'b0, 1'b0);
		send_text(CH_APOS,  1'b1, 1'b0, 1'b0);
		send_text(CH_QUOTE, 1'b0, 1'b0, 1'b0);
		send_text(CH_LT,    1'b0, 1'b0, 1'b0);
		send_text(CH_APOS,  1'b0, 1'b0, 1'b0);
		send_text(CH_BSL,   1'b0, 1'b0, 1'b0);
		send_text(CH_BSL,   1'b1, 1'b0, 1'b0);
		send_text(CH_BS,    1'b1, 1'b0, 1'b0);
		send_text(CH_FF,    1'b0, 1'b0, 1'b0);
		send_text(CH_LF,    1'b0, 1'b0, 1'b0);
		send_text(CH_CR,    1'b1, 1'b0, 1'b0);
		send_text(CH_TAB,   1'b0, 1'b0, 1'b0);
		send_text(8'h00,    1'b0, 1'b0, 1'b0);
		send_text(8'hFF,    1'b1, 1'b0, 1'b1);
		// Raw mode: quotes and backslash escapes are off
		set_json_quoting(1'b0);
		send_text(CH_QUOTE, 1'b0, 1'b1, 1'b1);
		send_text(CH_QUOTE, 1'b1, 1'b1, 1'b0);
		send_text(CH_BSL,   1'b1, 1'b0, 1'b0);
		send_text(CH_LF,    1'b0, 1'b0, 1'b0);
		send_text(CH_AMP,   1'b1, 1'b0, 1'b1);

		// Random strings in phases, alternating the quoting mode
		target = items_sent + RANDOM_ITEMS;
		phase = 0;
		while (items_sent < target) begin
			if (items_sent >= target - (RANDOM_ITEMS - phase * PHASE_ITEMS)) begin
				set_json_quoting(phase % 2 == 0);
				phase++;
			end
			quiet = (items_sent >= target - QUIET_ITEMS);
			send_string($urandom_range(1, 8), $urandom_range(0, 6) == 0);
		end

		// Drain and let any stray beat show up
		s_tvalid <= 1'b0;
		wait_drained();
		repeat (8) @(posedge clk);
		$display("sent %0d text beats, checked %0d escaped beats", items_sent,
			tracker.beats_seen);
		$display("quoting register written %0d times, %0d mismatches", mode_writes,
			tracker.errors);
		if (tracker.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/xje_pkg.sv
rtl/core/xje_front.sv
rtl/core/xje_queue.sv
rtl/core/xje_back.sv
rtl/core/xml_json_escape_encoder_unit.sv
dv/tb.sv
